### rtl/tsr_pkg.sv
// shared constants, types and codes of the triangle span rasteriser
package tsr_pkg;

   localparam int FRAME_WIDTH  = 320;
   localparam int FRAME_HEIGHT = 240;

   localparam int COORD_W = 12;
   localparam int FRAC_W  = 16;
   localparam int CH_W    = 8;
   localparam int PIX_W   = 3 * CH_W;
   localparam int COL_W   = 9;
   localparam int ROW_W   = 8;
   localparam int FUNC_W  = 2;
   localparam int DATA_W  = 32;
   localparam int PADDR_W = 2;

   localparam int DX_W    = COORD_W + 1;
   localparam int DIV_W   = COORD_W + 1;
   localparam int QUO_W   = COORD_W + FRAC_W;
   localparam int SLOPE_W = QUO_W + 1;
   localparam int POS_W   = COORD_W + FRAC_W + 6;
   localparam int XI_W    = POS_W - FRAC_W;
   localparam int YC_W    = COORD_W + 1;
   localparam int BASE_W  = COORD_W + $clog2(FRAME_WIDTH) + 1;

   localparam int MEM_DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int MEM_AW    = $clog2(MEM_DEPTH);

   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_DRAW  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd2;

   localparam logic [PADDR_W-1:0] REG_BACKGROUND = 2'd0;
   localparam logic [CH_W-1:0]    BG_RESET       = 8'd100;

   typedef struct packed {
      logic [FUNC_W-1:0]         func;
      logic signed [COORD_W-1:0] x0;
      logic signed [COORD_W-1:0] y0;
      logic signed [COORD_W-1:0] x1;
      logic signed [COORD_W-1:0] y1;
      logic signed [COORD_W-1:0] x2;
      logic signed [COORD_W-1:0] y2;
      logic signed [SLOPE_W-1:0] s_far;
      logic signed [SLOPE_W-1:0] s_up;
      logic signed [SLOPE_W-1:0] s_low;
      logic [PIX_W-1:0]          colour;
      logic [COL_W-1:0]          read_col;
      logic [ROW_W-1:0]          read_row;
   } cmd_type;

endpackage

### rtl/triangle_span_rasterizer_unit.sv
// top level of the triangle span rasteriser
//
// Flat-colour triangle fill into a 320 x 240 RGB frame store, seen as a queue
// on both sides. Every word pushed yields one result word. A clear writes the
// background level to all pixels, one pixel a cycle, in the back end. A draw
// first passes the front end, which runs three serial 28-step slope divisions;
// then, for each row inside the frame, the back end sets up the row, writes the
// pixels of the two spans of that row and steps on to the next row, and for
// each row above the frame it only steps on, from the top vertex to the clipped
// bottom. A two-word queue sits between front and back so a new word can be
// set up while the previous one is still being drawn; full stays high while
// the front end holds a word. Pixels never cleared or drawn read back
// undefined.
module triangle_span_rasterizer_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  logic [tsr_pkg::FUNC_W-1:0]          req_func,
   input  logic signed [tsr_pkg::COORD_W-1:0]  req_vertex_a_x,
   input  logic signed [tsr_pkg::COORD_W-1:0]  req_vertex_a_y,
   input  logic signed [tsr_pkg::COORD_W-1:0]  req_vertex_b_x,
   input  logic signed [tsr_pkg::COORD_W-1:0]  req_vertex_b_y,
   input  logic signed [tsr_pkg::COORD_W-1:0]  req_vertex_c_x,
   input  logic signed [tsr_pkg::COORD_W-1:0]  req_vertex_c_y,
   input  logic [tsr_pkg::CH_W-1:0]            req_fill_red,
   input  logic [tsr_pkg::CH_W-1:0]            req_fill_green,
   input  logic [tsr_pkg::CH_W-1:0]            req_fill_blue,
   input  logic [tsr_pkg::COL_W-1:0]           req_read_col,
   input  logic [tsr_pkg::ROW_W-1:0]           req_read_row,
   output logic                                empty,
   input  logic                                pop,
   output logic [tsr_pkg::CH_W-1:0]            rsp_pixel_red,
   output logic [tsr_pkg::CH_W-1:0]            rsp_pixel_green,
   output logic [tsr_pkg::CH_W-1:0]            rsp_pixel_blue,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [tsr_pkg::PADDR_W-1:0]         paddr,
   input  logic [tsr_pkg::DATA_W-1:0]          pwdata,
   output logic [tsr_pkg::DATA_W-1:0]          prdata,
   output logic                                pready
);
   logic [tsr_pkg::CH_W-1:0]  bg_ff, bg_in;
   tsr_pkg::cmd_type          f_data, q_rd;
   logic                      q_push, q_full, q_pop, q_empty;
   logic [tsr_pkg::PIX_W-1:0] pixel;

   assign pready = 1'b1;
   assign prdata = (paddr == tsr_pkg::REG_BACKGROUND) ?
                   tsr_pkg::DATA_W'(bg_ff) : '0;

   always_comb begin
      bg_in = bg_ff;
      if (psel && penable && pwrite && paddr == tsr_pkg::REG_BACKGROUND)
         bg_in = pwdata[tsr_pkg::CH_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bg_ff <= tsr_pkg::BG_RESET;
      end else begin
         bg_ff <= bg_in;
      end
   end

   tsr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (full),
      .func     (req_func),
      .ax       (req_vertex_a_x),
      .ay       (req_vertex_a_y),
      .bx       (req_vertex_b_x),
      .by       (req_vertex_b_y),
      .cx       (req_vertex_c_x),
      .cy       (req_vertex_c_y),
      .colour   ({req_fill_red, req_fill_green, req_fill_blue}),
      .read_col (req_read_col),
      .read_row (req_read_row),
      .q_data   (f_data),
      .q_push   (q_push),
      .q_full   (q_full)
   );

   tsr_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (f_data),
      .full    (q_full),
      .pop     (q_pop),
      .rd_data (q_rd),
      .empty   (q_empty)
   );

   tsr_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_data     (q_rd),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .background (bg_ff),
      .empty      (empty),
      .pop        (pop),
      .pixel      (pixel)
   );

   assign rsp_pixel_red   = pixel[3*tsr_pkg::CH_W-1:2*tsr_pkg::CH_W];
   assign rsp_pixel_green = pixel[2*tsr_pkg::CH_W-1:tsr_pkg::CH_W];
   assign rsp_pixel_blue  = pixel[tsr_pkg::CH_W-1:0];

`ifndef NO_ASSERTIONS
   a_queue_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(q_push && q_full))
      else $error("command queue pushed while full");

   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty)
      else $error("result word lost before pop");

   a_front_busy: assert property (@(posedge clock) disable iff (reset)
      (push && !full) |=> full)
      else $error("front end free right after taking a word");

   a_pop_has_data: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("back end took from an empty queue");
`endif

endmodule

### rtl/tsr_divider.sv
// serial signed divider for edge slopes, one quotient bit per cycle
module tsr_divider (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic signed [tsr_pkg::DX_W-1:0]    dividend,
   input  logic [tsr_pkg::DIV_W-1:0]          divisor,
   output logic                               done,
   output logic signed [tsr_pkg::SLOPE_W-1:0] quotient
);
   localparam int QW    = tsr_pkg::QUO_W;
   localparam int DW    = tsr_pkg::DIV_W;
   localparam int CNT_W = $clog2(QW + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [QW-1:0]     quo_ff, quo_in;
   logic [DW-1:0]     dvs_ff, dvs_in;
   logic              neg_ff, neg_in;
   logic [tsr_pkg::DX_W-1:0] mag;
   logic [DW:0]       rem_sh;
   logic [DW:0]       diff;

   always_comb begin
      mag     = dividend[tsr_pkg::DX_W-1] ? -dividend : dividend;
      rem_sh  = {rem_ff, quo_ff[QW-1]};
      diff    = rem_sh - {1'b0, dvs_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(QW);
         rem_in  = '0;
         quo_in  = {mag[tsr_pkg::COORD_W-1:0], {tsr_pkg::FRAC_W{1'b0}}};
         dvs_in  = divisor;
         neg_in  = dividend[tsr_pkg::DX_W-1];
      end else if (busy_ff) begin
         rem_in = diff[DW] ? rem_sh[DW-1:0] : diff[DW-1:0];
         quo_in = {quo_ff[QW-2:0], ~diff[DW]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done     = done_ff;
   assign quotient = neg_ff ? -$signed({1'b0, quo_ff}) : $signed({1'b0, quo_ff});

endmodule

### rtl/tsr_front.sv
// front end: takes words, sorts vertices, works out the three slopes of a draw
module tsr_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              push,
   output logic                              full,
   input  logic [tsr_pkg::FUNC_W-1:0]        func,
   input  logic signed [tsr_pkg::COORD_W-1:0] ax,
   input  logic signed [tsr_pkg::COORD_W-1:0] ay,
   input  logic signed [tsr_pkg::COORD_W-1:0] bx,
   input  logic signed [tsr_pkg::COORD_W-1:0] by,
   input  logic signed [tsr_pkg::COORD_W-1:0] cx,
   input  logic signed [tsr_pkg::COORD_W-1:0] cy,
   input  logic [tsr_pkg::PIX_W-1:0]         colour,
   input  logic [tsr_pkg::COL_W-1:0]         read_col,
   input  logic [tsr_pkg::ROW_W-1:0]         read_row,
   output tsr_pkg::cmd_type                  q_data,
   output logic                              q_push,
   input  logic                              q_full
);
   localparam logic [1:0] F_IDLE   = 2'd0;
   localparam logic [1:0] F_DSTART = 2'd1;
   localparam logic [1:0] F_DWAIT  = 2'd2;
   localparam logic [1:0] F_PUSH   = 2'd3;
   localparam logic [1:0] IDX_FAR  = 2'd0;
   localparam logic [1:0] IDX_UP   = 2'd1;
   localparam logic [1:0] IDX_LOW  = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [1:0]       idx_ff, idx_in;
   tsr_pkg::cmd_type cmd_ff, cmd_in;

   logic signed [tsr_pkg::COORD_W-1:0] x0, y0, x1, y1, x2, y2, t;
   logic signed [tsr_pkg::DX_W-1:0]    dx;
   logic signed [tsr_pkg::DX_W-1:0]    dy;
   logic [tsr_pkg::DIV_W-1:0]          dvs;
   logic                               div_start;
   logic                               div_done;
   logic signed [tsr_pkg::SLOPE_W-1:0] div_q;

   tsr_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dx),
      .divisor  (dvs),
      .done     (div_done),
      .quotient (div_q)
   );

   always_comb begin
      t  = '0;
      x0 = ax; y0 = ay; x1 = bx; y1 = by; x2 = cx; y2 = cy;
      if (y1 > y2) begin
         t = x1; x1 = x2; x2 = t;
         t = y1; y1 = y2; y2 = t;
      end
      if (y0 > y1) begin
         t = x0; x0 = x1; x1 = t;
         t = y0; y0 = y1; y1 = t;
      end
      if (y1 > y2) begin
         t = x1; x1 = x2; x2 = t;
         t = y1; y1 = y2; y2 = t;
      end
   end

   always_comb begin
      case (idx_ff)
         IDX_FAR: begin
            dx = tsr_pkg::DX_W'(cmd_ff.x2) - tsr_pkg::DX_W'(cmd_ff.x0);
            dy = tsr_pkg::DX_W'(cmd_ff.y2) - tsr_pkg::DX_W'(cmd_ff.y0);
         end
         IDX_UP: begin
            dx = tsr_pkg::DX_W'(cmd_ff.x1) - tsr_pkg::DX_W'(cmd_ff.x0);
            dy = tsr_pkg::DX_W'(cmd_ff.y1) - tsr_pkg::DX_W'(cmd_ff.y0);
         end
         default: begin
            dx = tsr_pkg::DX_W'(cmd_ff.x2) - tsr_pkg::DX_W'(cmd_ff.x1);
            dy = tsr_pkg::DX_W'(cmd_ff.y2) - tsr_pkg::DX_W'(cmd_ff.y1);
         end
      endcase
      dvs = dy + 1'b1;
   end

   always_comb begin
      state_in  = state_ff;
      idx_in    = idx_ff;
      cmd_in    = cmd_ff;
      div_start = 1'b0;
      q_push    = 1'b0;
      case (state_ff)
         F_IDLE: begin
            if (push) begin
               cmd_in.func     = func;
               cmd_in.x0       = x0;
               cmd_in.y0       = y0;
               cmd_in.x1       = x1;
               cmd_in.y1       = y1;
               cmd_in.x2       = x2;
               cmd_in.y2       = y2;
               cmd_in.colour   = colour;
               cmd_in.read_col = read_col;
               cmd_in.read_row = read_row;
               idx_in          = IDX_FAR;
               state_in        = (func == tsr_pkg::FUNC_DRAW) ? F_DSTART : F_PUSH;
            end
         end
         F_DSTART: begin
            div_start = 1'b1;
            state_in  = F_DWAIT;
         end
         F_DWAIT: begin
            if (div_done) begin
               case (idx_ff)
                  IDX_FAR: cmd_in.s_far = div_q;
                  IDX_UP:  cmd_in.s_up  = div_q;
                  default: cmd_in.s_low = div_q;
               endcase
               if (idx_ff == IDX_LOW) begin
                  state_in = F_PUSH;
               end else begin
                  idx_in   = idx_ff + 1'b1;
                  state_in = F_DSTART;
               end
            end
         end
         default: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      idx_ff <= idx_in;
      cmd_ff <= cmd_in;
   end

   assign full   = (state_ff != F_IDLE);
   assign q_data = cmd_ff;

endmodule

### rtl/tsr_queue.sv
// two-entry command queue between front and back
module tsr_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  tsr_pkg::cmd_type wr_data,
   output logic             full,
   input  logic             pop,
   output tsr_pkg::cmd_type rd_data,
   output logic             empty
);
   tsr_pkg::cmd_type mem_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic       do_push, do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (do_push) wr_ptr_ff <= ~wr_ptr_ff;
         if (do_pop)  rd_ptr_ff <= ~rd_ptr_ff;
         if (do_push && !do_pop) cnt_ff <= cnt_ff + 1'b1;
         else if (do_pop && !do_push) cnt_ff <= cnt_ff - 1'b1;
      end
      if (do_push) mem_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

### rtl/tsr_back.sv
// back end: frame store, clear sweep, span walker, pixel read, result register
module tsr_back (
   input  logic                       clock,
   input  logic                       reset,
   input  tsr_pkg::cmd_type           q_data,
   input  logic                       q_empty,
   output logic                       q_pop,
   input  logic [tsr_pkg::CH_W-1:0]   background,
   output logic                       empty,
   input  logic                       pop,
   output logic [tsr_pkg::PIX_W-1:0]  pixel
);
   localparam logic [2:0] B_IDLE    = 3'd0;
   localparam logic [2:0] B_CLEAR   = 3'd1;
   localparam logic [2:0] B_ROWSET  = 3'd2;
   localparam logic [2:0] B_SPAN1   = 3'd3;
   localparam logic [2:0] B_SPAN2   = 3'd4;
   localparam logic [2:0] B_ROWNEXT = 3'd5;
   localparam logic [2:0] B_READ    = 3'd6;
   localparam logic [2:0] B_DONE    = 3'd7;

   localparam int PW = tsr_pkg::POS_W;
   localparam int XW = tsr_pkg::XI_W;
   localparam int BW = tsr_pkg::BASE_W;
   localparam int YW = tsr_pkg::YC_W;
   localparam int AW = tsr_pkg::MEM_AW;
   localparam logic signed [XW-1:0] XMAX     = XW'(tsr_pkg::FRAME_WIDTH - 1);
   localparam logic signed [YW-1:0] YMAX     = YW'(tsr_pkg::FRAME_HEIGHT - 1);
   localparam logic signed [BW-1:0] ROW_STEP = BW'(tsr_pkg::FRAME_WIDTH);
   localparam logic signed [PW-1:0] FRAC_M   = PW'((1 << tsr_pkg::FRAC_W) - 1);
   localparam logic signed [PW-1:0] XF_LIM   =
      PW'(tsr_pkg::FRAME_WIDTH) <<< tsr_pkg::FRAC_W;

   logic [2:0]                 state_ff, state_in;
   logic signed [PW-1:0]       xf_ff, xf_in, xt_ff, xt_in;
   logic signed [tsr_pkg::SLOPE_W-1:0] sfar_ff, sfar_in, sup_ff, sup_in, slow_ff, slow_in;
   logic signed [YW-1:0]       y_ff, y_in, y1_ff, y1_in, yend_ff, yend_in;
   logic signed [BW-1:0]       base_ff, base_in;
   logic signed [XW-1:0]       x_ff, x_in;
   logic signed [XW-1:0]       lo1_ff, lo1_in, hi1_ff, hi1_in, lo2_ff, lo2_in, hi2_ff, hi2_in;
   logic [AW-1:0]              clr_ff, clr_in;
   logic [AW-1:0]              rd_addr_ff, rd_addr_in;
   logic                       in_frame_ff, in_frame_in;
   logic                       is_read_ff, is_read_in;
   logic [tsr_pkg::PIX_W-1:0]  colour_ff, colour_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [tsr_pkg::PIX_W-1:0]  rsp_pix_ff, rsp_pix_in;

   logic [tsr_pkg::PIX_W-1:0]  mem [tsr_pkg::MEM_DEPTH];
   logic [tsr_pkg::PIX_W-1:0]  mem_rd_ff;
   logic                       mem_we;
   logic [AW-1:0]              mem_wa;
   logic [tsr_pkg::PIX_W-1:0]  mem_wd;

   logic signed [PW-1:0] xf_tr, xt_ce;
   logic signed [XW-1:0] fl_xf, fl_xt, tr_xf, ce_xt;
   logic signed [YW-1:0] y0_ext, y2_ext;

   always_comb begin
      xf_tr  = xf_ff + (xf_ff[PW-1] ? FRAC_M : PW'(0));
      xt_ce  = xt_ff + FRAC_M;
      fl_xf  = xf_ff[PW-1:tsr_pkg::FRAC_W];
      fl_xt  = xt_ff[PW-1:tsr_pkg::FRAC_W];
      tr_xf  = xf_tr[PW-1:tsr_pkg::FRAC_W];
      ce_xt  = xt_ce[PW-1:tsr_pkg::FRAC_W];
      y0_ext = YW'(q_data.y0);
      y2_ext = YW'(q_data.y2);
   end

   always_comb begin
      state_in     = state_ff;
      xf_in        = xf_ff;
      xt_in        = xt_ff;
      sfar_in      = sfar_ff;
      sup_in       = sup_ff;
      slow_in      = slow_ff;
      y_in         = y_ff;
      y1_in        = y1_ff;
      yend_in      = yend_ff;
      base_in      = base_ff;
      x_in         = x_ff;
      lo1_in       = lo1_ff;
      hi1_in       = hi1_ff;
      lo2_in       = lo2_ff;
      hi2_in       = hi2_ff;
      clr_in       = clr_ff;
      rd_addr_in   = rd_addr_ff;
      in_frame_in  = in_frame_ff;
      is_read_in   = is_read_ff;
      colour_in    = colour_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pix_in   = rsp_pix_ff;
      q_pop        = 1'b0;
      mem_we       = 1'b0;
      mem_wa       = AW'(base_ff + BW'(x_ff));
      mem_wd       = colour_ff;

      if (pop && rsp_valid_ff) rsp_valid_in = 1'b0;

      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               q_pop       = 1'b1;
               is_read_in  = 1'b0;
               colour_in   = q_data.colour;
               sfar_in     = q_data.s_far;
               sup_in      = q_data.s_up;
               slow_in     = q_data.s_low;
               xf_in       = PW'(q_data.x0) <<< tsr_pkg::FRAC_W;
               xt_in       = (PW'(q_data.x0) <<< tsr_pkg::FRAC_W) + PW'(q_data.s_up);
               y_in        = y0_ext;
               y1_in       = YW'(q_data.y1);
               yend_in     = (y2_ext > YMAX) ? YMAX : y2_ext;
               base_in     = BW'(BW'(q_data.y0) * ROW_STEP);
               clr_in      = '0;
               rd_addr_in  = AW'(q_data.read_row * tsr_pkg::FRAME_WIDTH + q_data.read_col);
               in_frame_in = (q_data.read_col < tsr_pkg::COL_W'(tsr_pkg::FRAME_WIDTH)) &&
                             (q_data.read_row < tsr_pkg::ROW_W'(tsr_pkg::FRAME_HEIGHT));
               case (q_data.func)
                  tsr_pkg::FUNC_CLEAR: state_in = B_CLEAR;
                  tsr_pkg::FUNC_DRAW:  state_in = B_ROWSET;
                  tsr_pkg::FUNC_READ: begin
                     is_read_in = 1'b1;
                     state_in   = B_READ;
                  end
                  default:             state_in = B_DONE;
               endcase
            end
         end
         B_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = clr_ff;
            mem_wd = {3{background}};
            clr_in = clr_ff + 1'b1;
            if (clr_ff == AW'(tsr_pkg::MEM_DEPTH - 1)) state_in = B_DONE;
         end
         B_ROWSET: begin
            if (y_ff > yend_ff) begin
               state_in = B_DONE;
            end else if (y_ff[YW-1]) begin
               state_in = B_ROWNEXT;
            end else begin
               lo1_in   = fl_xf[XW-1] ? XW'(0) : fl_xf;
               hi1_in   = (fl_xt > XMAX) ? XMAX : fl_xt;
               hi2_in   = (xf_ff < XF_LIM) ? tr_xf : XMAX;
               lo2_in   = ce_xt[XW-1] ? XW'(0) : ce_xt;
               x_in     = fl_xf[XW-1] ? XW'(0) : fl_xf;
               state_in = B_SPAN1;
            end
         end
         B_SPAN1: begin
            if (x_ff > hi1_ff) begin
               x_in     = lo2_ff;
               state_in = B_SPAN2;
            end else begin
               mem_we = 1'b1;
               x_in   = x_ff + 1'b1;
            end
         end
         B_SPAN2: begin
            if (x_ff > hi2_ff) begin
               state_in = B_ROWNEXT;
            end else begin
               mem_we = 1'b1;
               x_in   = x_ff + 1'b1;
            end
         end
         B_ROWNEXT: begin
            xf_in    = xf_ff + PW'(sfar_ff);
            xt_in    = xt_ff + PW'((y_ff < y1_ff) ? sup_ff : slow_ff);
            y_in     = y_ff + 1'b1;
            base_in  = base_ff + ROW_STEP;
            state_in = B_ROWSET;
         end
         B_READ: begin
            state_in = B_DONE;
         end
         default: begin
            if (!rsp_valid_ff || pop) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in   = (is_read_ff && in_frame_ff) ? mem_rd_ff : '0;
               state_in     = B_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) mem[mem_wa] <= mem_wd;
      mem_rd_ff <= mem[rd_addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      xf_ff       <= xf_in;
      xt_ff       <= xt_in;
      sfar_ff     <= sfar_in;
      sup_ff      <= sup_in;
      slow_ff     <= slow_in;
      y_ff        <= y_in;
      y1_ff       <= y1_in;
      yend_ff     <= yend_in;
      base_ff     <= base_in;
      x_ff        <= x_in;
      lo1_ff      <= lo1_in;
      hi1_ff      <= hi1_in;
      lo2_ff      <= lo2_in;
      hi2_ff      <= hi2_in;
      clr_ff      <= clr_in;
      rd_addr_ff  <= rd_addr_in;
      in_frame_ff <= in_frame_in;
      is_read_ff  <= is_read_in;
      colour_ff   <= colour_in;
      rsp_pix_ff  <= rsp_pix_in;
   end

   assign empty = !rsp_valid_ff;
   assign pixel = rsp_pix_ff;

endmodule
